// ===== src/coin_change_dispenser_defines.svh =====
// assertion macros for the coin change dispenser
`ifndef COIN_CHANGE_DISPENSER_DEFINES_SVH
`define COIN_CHANGE_DISPENSER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked on every rising edge out of reset
`define CCD_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("coin change dispenser check failed");
// next-cycle implication
`define CCD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("coin change dispenser check failed");
`else
`define CCD_ASSERT(lbl, ante, cons)
`define CCD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== src/ccd_pkg.sv =====
// shared constants, tables and types of the coin change dispenser
package ccd_pkg;

  localparam int NUM_COINS  = 10;
  localparam int STOCK_W    = 16;
  localparam int MAX_AMOUNT = 2000;
  localparam int RESULT_CAP = 10;

  localparam int IDX_W   = $clog2(NUM_COINS);
  localparam int AMT_W   = $clog2(MAX_AMOUNT + 1);
  localparam int RCP_SH  = AMT_W + 1;
  localparam int RECIP_W = RCP_SH + 1;
  localparam int DENOM_W = 17;
  localparam int SUM_W   = ((STOCK_W > AMT_W) ? STOCK_W : AMT_W) + 1;
  localparam int CNT_W   = $clog2(RESULT_CAP + 1);

  localparam logic [STOCK_W-1:0] STOCK_MAX   = '1;
  localparam logic [STOCK_W-1:0] STOCK_RESET = STOCK_W'(5);

  // port field widths
  localparam int IN_AMT_W   = 11;
  localparam int PREF_W     = 4;
  localparam int STATUS_W   = 2;
  localparam int COIN_IDX_W = 4;
  localparam int COUNT_W    = 11;
  localparam int EMPTY_W    = 10;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_PAD_W  = OUT_DATA_W - COIN_IDX_W - COUNT_W - EMPTY_W;

  typedef enum logic [STATUS_W-1:0] {
    ST_PAID  = 2'd0,
    ST_SHORT = 2'd1,
    ST_LOW   = 2'd2
  } status_t;

  // coin values in cents
  localparam logic [DENOM_W-1:0] DENOM [16] = '{
    17'd1, 17'd2, 17'd5, 17'd10, 17'd20, 17'd50, 17'd100, 17'd200,
    17'd500, 17'd1000, 17'd2000, 17'd5000, 17'd10000, 17'd20000,
    17'd50000, 17'd100000
  };

  // floor(2^RCP_SH / value), quotient estimate is exact or one low
  localparam logic [RECIP_W-1:0] RECIP [16] = '{
    RECIP_W'((64'd1 << RCP_SH) / 64'd1),
    RECIP_W'((64'd1 << RCP_SH) / 64'd2),
    RECIP_W'((64'd1 << RCP_SH) / 64'd5),
    RECIP_W'((64'd1 << RCP_SH) / 64'd10),
    RECIP_W'((64'd1 << RCP_SH) / 64'd20),
    RECIP_W'((64'd1 << RCP_SH) / 64'd50),
    RECIP_W'((64'd1 << RCP_SH) / 64'd100),
    RECIP_W'((64'd1 << RCP_SH) / 64'd200),
    RECIP_W'((64'd1 << RCP_SH) / 64'd500),
    RECIP_W'((64'd1 << RCP_SH) / 64'd1000),
    RECIP_W'((64'd1 << RCP_SH) / 64'd2000),
    RECIP_W'((64'd1 << RCP_SH) / 64'd5000),
    RECIP_W'((64'd1 << RCP_SH) / 64'd10000),
    RECIP_W'((64'd1 << RCP_SH) / 64'd20000),
    RECIP_W'((64'd1 << RCP_SH) / 64'd50000),
    RECIP_W'((64'd1 << RCP_SH) / 64'd100000)
  };

  typedef struct packed {
    logic [AMT_W-1:0] quo;
    logic [AMT_W-1:0] rem;
  } div_res_t;

endpackage

// ===== src/ccd_ram.sv =====
// generic single-port-write ram with registered read
module ccd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/ccd_cdiv.sv =====
// two-stage divide by a coin value via reciprocal multiply and one correction
module ccd_cdiv (
  input  logic                        clk,
  input  logic [ccd_pkg::AMT_W-1:0]   x,
  input  logic [ccd_pkg::IDX_W-1:0]   sel,
  output ccd_pkg::div_res_t           res
);

  localparam int PROD_W = ccd_pkg::AMT_W + ccd_pkg::RECIP_W;

  logic [PROD_W-1:0]             prod_r;
  logic [ccd_pkg::AMT_W-1:0]     x1_r;
  logic [ccd_pkg::IDX_W-1:0]     sel1_r;
  logic [ccd_pkg::AMT_W-1:0]     q0;
  logic [ccd_pkg::AMT_W-1:0]     q0_r;
  logic [ccd_pkg::AMT_W-1:0]     qd_r;
  logic [ccd_pkg::AMT_W-1:0]     x2_r;
  logic [ccd_pkg::DENOM_W-1:0]   d2_r;
  logic [ccd_pkg::AMT_W-1:0]     r0;

  assign q0 = prod_r[ccd_pkg::RCP_SH +: ccd_pkg::AMT_W];

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(x) * PROD_W'(ccd_pkg::RECIP[sel]);
    x1_r   <= x;
    sel1_r <= sel;
    // estimate times coin value; nonzero estimate means the value fits
    q0_r   <= q0;
    qd_r   <= ccd_pkg::AMT_W'(q0 * ccd_pkg::DENOM[sel1_r][ccd_pkg::AMT_W-1:0]);
    x2_r   <= x1_r;
    d2_r   <= ccd_pkg::DENOM[sel1_r];
  end

  assign r0 = x2_r - qd_r;

  always_comb begin
    if (ccd_pkg::DENOM_W'(r0) >= d2_r) begin
      res.quo = q0_r + ccd_pkg::AMT_W'(1);
      res.rem = r0 - ccd_pkg::AMT_W'(d2_r);
    end else begin
      res.quo = q0_r;
      res.rem = r0;
    end
  end

endmodule

// ===== src/coin_change_dispenser.sv =====
// coin change dispenser top level: sequencer over the coin stock ram
// a payment below price gives its single result straight from the price check;
//   otherwise one pass over each denomination (read, multiply, update, plus short and
//   subtract where a coin runs short), then a commit pass (read pending, write stock back)
// one purchase at a time, paced by the per-denomination visits of the single stock ram
//   and the pipelined reciprocal divider
// reset: a clearing pass loads 5 coins into every stock entry, no item taken
`include "coin_change_dispenser_defines.svh"

module coin_change_dispenser (
  input  logic                             clk,
  input  logic                             rst_n,
  // purchase items
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // inserted_cents[10:0], price_cents[21:11], preferred_coin[25:22], zero fill
  input  logic [ccd_pkg::IN_DATA_W-1:0]    in_tdata,
  // result items
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // coin_index[3:0], coin_count[14:4], empty_mask[24:15], zero fill
  output logic [ccd_pkg::OUT_DATA_W-1:0]   out_tdata,
  // status[1:0]
  output logic [ccd_pkg::STATUS_W-1:0]     out_tuser,
  output logic                             out_tlast
);

  typedef enum logic [3:0] {
    S_INIT,   // clearing pass after reset
    S_IDLE,
    S_CHECK,  // price check
    S_RD,     // read stock entry, start both divides
    S_MUL,
    S_UPD,    // take in, pay out, stage to the pending ram
    S_SHORT,  // coin ran short: stock times value
    S_SUB,
    S_DONE,   // decide success or abort
    S_CRD,    // commit pass: read pending entry
    S_CWR,    // write stock back, give a result
    S_CEND
  } state_t;

  typedef struct packed {
    logic [ccd_pkg::STOCK_W-1:0] stock;
    logic [ccd_pkg::AMT_W-1:0]   used;
  } pend_t;

  state_t                          state_r;
  logic [ccd_pkg::IDX_W-1:0]       idx_r;
  logic [ccd_pkg::AMT_W-1:0]       paid_r;
  logic [ccd_pkg::AMT_W-1:0]       price_r;
  logic [ccd_pkg::IDX_W-1:0]       pref_r;
  logic [ccd_pkg::AMT_W-1:0]       rest_r;
  logic [ccd_pkg::AMT_W-1:0]       change_r;
  logic [ccd_pkg::STOCK_W-1:0]     new_r;
  logic [ccd_pkg::AMT_W-1:0]       short_r;
  logic [ccd_pkg::NUM_COINS-1:0]   used_mask_r;
  logic [ccd_pkg::NUM_COINS-1:0]   new_mask_r;
  logic [ccd_pkg::NUM_COINS-1:0]   empty_mask_r;
  logic [ccd_pkg::CNT_W-1:0]       k_r;

  logic                            out_valid_r;
  logic [ccd_pkg::STATUS_W-1:0]    out_status_r;
  logic [ccd_pkg::COIN_IDX_W-1:0]  out_index_r;
  logic [ccd_pkg::COUNT_W-1:0]     out_count_r;
  logic [ccd_pkg::EMPTY_W-1:0]     out_mask_r;
  logic                            out_last_r;

  // input fields, saturated
  logic [ccd_pkg::IN_AMT_W-1:0]    in_ins;
  logic [ccd_pkg::IN_AMT_W-1:0]    in_price;
  logic [ccd_pkg::PREF_W-1:0]      in_pref;
  logic [ccd_pkg::AMT_W-1:0]       paid_sat;
  logic [ccd_pkg::AMT_W-1:0]       price_sat;
  logic [ccd_pkg::IDX_W-1:0]       pref_sat;

  // stock and pending rams
  logic                            stock_we;
  logic [ccd_pkg::STOCK_W-1:0]     stock_wdata;
  logic                            stock_re;
  logic [ccd_pkg::STOCK_W-1:0]     stock_rdata;
  logic                            pend_we;
  pend_t                           pend_wdata;
  logic                            pend_re;
  pend_t                           pend_rdata;

  ccd_pkg::div_res_t               div_in;
  ccd_pkg::div_res_t               div_ch;

  logic [ccd_pkg::SUM_W-1:0]       sum;
  logic [ccd_pkg::STOCK_W-1:0]     new_stock;
  logic                            in_change;
  logic                            short_fall;
  logic [ccd_pkg::AMT_W-1:0]       take;
  logic [ccd_pkg::STOCK_W-1:0]     final_stock;
  logic                            out_free;
  logic                            emit;
  logic [ccd_pkg::NUM_COINS-1:0]   lower_mask;
  logic                            emit_last;
  logic                            in_acc;
  logic                            out_load;

  assign in_ins   = in_tdata[ccd_pkg::IN_AMT_W-1:0];
  assign in_price = in_tdata[2*ccd_pkg::IN_AMT_W-1:ccd_pkg::IN_AMT_W];
  assign in_pref  = in_tdata[2*ccd_pkg::IN_AMT_W +: ccd_pkg::PREF_W];

  assign paid_sat  = (32'(in_ins) > ccd_pkg::MAX_AMOUNT) ?
                     ccd_pkg::AMT_W'(ccd_pkg::MAX_AMOUNT) : ccd_pkg::AMT_W'(in_ins);
  assign price_sat = (32'(in_price) > ccd_pkg::MAX_AMOUNT) ?
                     ccd_pkg::AMT_W'(ccd_pkg::MAX_AMOUNT) : ccd_pkg::AMT_W'(in_price);
  assign pref_sat  = (32'(in_pref) > ccd_pkg::NUM_COINS - 1) ?
                     ccd_pkg::IDX_W'(ccd_pkg::NUM_COINS - 1) : ccd_pkg::IDX_W'(in_pref);

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // one stock entry per denomination
  ccd_ram #(
    .WIDTH (ccd_pkg::STOCK_W),
    .DEPTH (ccd_pkg::NUM_COINS)
  ) u_stock (
    .clk   (clk),
    .we    (stock_we),
    .waddr (idx_r),
    .wdata (stock_wdata),
    .re    (stock_re),
    .raddr (idx_r),
    .rdata (stock_rdata)
  );

  // staged new stock and coins paid, committed only on success
  ccd_ram #(
    .WIDTH ($bits(pend_t)),
    .DEPTH (ccd_pkg::NUM_COINS)
  ) u_pend (
    .clk   (clk),
    .we    (pend_we),
    .waddr (idx_r),
    .wdata (pend_wdata),
    .re    (pend_re),
    .raddr (idx_r),
    .rdata (pend_rdata)
  );

  // greedy split of the payment
  ccd_cdiv u_div_in (
    .clk (clk),
    .x   (rest_r),
    .sel (idx_r),
    .res (div_in)
  );

  // greedy split of the change
  ccd_cdiv u_div_ch (
    .clk (clk),
    .x   (change_r),
    .sel (idx_r),
    .res (div_ch)
  );

  // take in, saturating, then pay out what the stock allows
  always_comb begin
    sum = ccd_pkg::SUM_W'(stock_rdata) + ccd_pkg::SUM_W'(div_in.quo);
    if (sum > ccd_pkg::SUM_W'(ccd_pkg::STOCK_MAX)) begin
      new_stock = ccd_pkg::STOCK_MAX;
    end else begin
      new_stock = ccd_pkg::STOCK_W'(sum);
    end
    in_change   = (idx_r <= pref_r);
    short_fall  = in_change &&
                  (ccd_pkg::SUM_W'(div_ch.quo) > ccd_pkg::SUM_W'(new_stock));
    take        = in_change ? div_ch.quo : '0;
    final_stock = new_stock - ccd_pkg::STOCK_W'(take);
  end

  // ram control
  always_comb begin
    stock_we    = (state_r == S_INIT) || (state_r == S_CWR);
    stock_wdata = (state_r == S_INIT) ? ccd_pkg::STOCK_RESET : pend_rdata.stock;
    stock_re    = (state_r == S_RD);
    pend_re     = (state_r == S_CRD);
    pend_we     = ((state_r == S_UPD) && !short_fall) || (state_r == S_SUB);
    if (state_r == S_SUB) begin
      pend_wdata.stock = '0;
      pend_wdata.used  = ccd_pkg::AMT_W'(new_r);
    end else begin
      pend_wdata.stock = final_stock;
      pend_wdata.used  = take;
    end
  end

  // result selection in the commit pass
  assign lower_mask = (ccd_pkg::NUM_COINS'(1) << idx_r) - ccd_pkg::NUM_COINS'(1);
  assign emit       = (pend_rdata.used != '0) &&
                      (32'(k_r) < ccd_pkg::RESULT_CAP);
  assign emit_last  = ((used_mask_r & lower_mask) == '0) ||
                      (32'(k_r) == ccd_pkg::RESULT_CAP - 1);

  // a result item is loaded into the output register this cycle
  assign out_load = out_free &&
                    (((state_r == S_CHECK) && (paid_r < price_r)) ||
                     ((state_r == S_DONE) && (change_r != '0)) ||
                     ((state_r == S_CWR) && emit) ||
                     ((state_r == S_CEND) && (k_r == '0)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      idx_r        <= '0;
      out_valid_r  <= 1'b0;
      empty_mask_r <= '0;
      k_r          <= '0;
    end else begin
      if (out_valid_r && out_tready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_INIT: begin
          if (idx_r == ccd_pkg::IDX_W'(ccd_pkg::NUM_COINS - 1)) begin
            state_r <= S_IDLE;
          end else begin
            idx_r <= idx_r + ccd_pkg::IDX_W'(1);
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            paid_r  <= paid_sat;
            price_r <= price_sat;
            pref_r  <= pref_sat;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (paid_r < price_r) begin
            // payment below price: stock untouched
            if (out_free) begin
              out_valid_r  <= 1'b1;
              out_status_r <= ccd_pkg::ST_LOW;
              out_index_r  <= '0;
              out_count_r  <= '0;
              out_mask_r   <= ccd_pkg::EMPTY_W'(empty_mask_r);
              out_last_r   <= 1'b1;
              state_r      <= S_IDLE;
            end
          end else begin
            rest_r      <= paid_r;
            change_r    <= paid_r - price_r;
            idx_r       <= ccd_pkg::IDX_W'(ccd_pkg::NUM_COINS - 1);
            used_mask_r <= '0;
            new_mask_r  <= '0;
            state_r     <= S_RD;
          end
        end
        S_RD: begin
          state_r <= S_MUL;
        end
        S_MUL: begin
          state_r <= S_UPD;
        end
        S_UPD: begin
          rest_r <= div_in.rem;
          new_r  <= new_stock;
          if (short_fall) begin
            state_r <= S_SHORT;
          end else begin
            if (in_change) begin
              change_r <= div_ch.rem;
            end
            used_mask_r[idx_r] <= (take != '0);
            new_mask_r[idx_r]  <= (final_stock == '0);
            if (idx_r == '0) begin
              state_r <= S_DONE;
            end else begin
              idx_r   <= idx_r - ccd_pkg::IDX_W'(1);
              state_r <= S_RD;
            end
          end
        end
        S_SHORT: begin
          // whole stock of this coin goes out
          short_r <= ccd_pkg::AMT_W'(ccd_pkg::AMT_W'(new_r) *
                     ccd_pkg::DENOM[idx_r][ccd_pkg::AMT_W-1:0]);
          state_r <= S_SUB;
        end
        S_SUB: begin
          change_r           <= change_r - short_r;
          used_mask_r[idx_r] <= (new_r != '0);
          new_mask_r[idx_r]  <= 1'b1;
          if (idx_r == '0) begin
            state_r <= S_DONE;
          end else begin
            idx_r   <= idx_r - ccd_pkg::IDX_W'(1);
            state_r <= S_RD;
          end
        end
        S_DONE: begin
          if (change_r != '0) begin
            // abort: pending entries are dropped, stock never written
            if (out_free) begin
              out_valid_r  <= 1'b1;
              out_status_r <= ccd_pkg::ST_SHORT;
              out_index_r  <= '0;
              out_count_r  <= '0;
              out_mask_r   <= ccd_pkg::EMPTY_W'(empty_mask_r);
              out_last_r   <= 1'b1;
              state_r      <= S_IDLE;
            end
          end else begin
            empty_mask_r <= new_mask_r;
            idx_r        <= ccd_pkg::IDX_W'(ccd_pkg::NUM_COINS - 1);
            k_r          <= '0;
            state_r      <= S_CRD;
          end
        end
        S_CRD: begin
          state_r <= S_CWR;
        end
        S_CWR: begin
          // stock write repeats harmlessly while the result waits
          if (!emit || out_free) begin
            if (emit) begin
              out_valid_r  <= 1'b1;
              out_status_r <= ccd_pkg::ST_PAID;
              out_index_r  <= ccd_pkg::COIN_IDX_W'(idx_r);
              out_count_r  <= ccd_pkg::COUNT_W'(pend_rdata.used);
              out_mask_r   <= ccd_pkg::EMPTY_W'(empty_mask_r);
              out_last_r   <= emit_last;
              k_r          <= k_r + ccd_pkg::CNT_W'(1);
            end
            if (idx_r == '0) begin
              state_r <= S_CEND;
            end else begin
              idx_r   <= idx_r - ccd_pkg::IDX_W'(1);
              state_r <= S_CRD;
            end
          end
        end
        S_CEND: begin
          if (k_r != '0) begin
            state_r <= S_IDLE;
          end else if (out_free) begin
            // exact payment: one empty result
            out_valid_r  <= 1'b1;
            out_status_r <= ccd_pkg::ST_PAID;
            out_index_r  <= '0;
            out_count_r  <= '0;
            out_mask_r   <= ccd_pkg::EMPTY_W'(empty_mask_r);
            out_last_r   <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{ccd_pkg::OUT_PAD_W{1'b0}}, out_mask_r, out_count_r, out_index_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

  // failed and rejected purchases give a single result
  `CCD_ASSERT(a_fail_single, out_valid_r && (out_status_r != ccd_pkg::ST_PAID), out_last_r)
  // a result that is followed by more always carries coins
  `CCD_ASSERT(a_more_has_coins, out_valid_r && !out_last_r, out_count_r != '0)
  // an aborted purchase never reaches the commit pass
  `CCD_ASSERT_NEXT(a_abort_no_commit, (state_r == S_DONE) && (change_r != '0), state_r != S_CRD)
  // change owed never grows while coins are paid out
  `CCD_ASSERT_NEXT(a_change_down, (state_r == S_UPD) || (state_r == S_SUB), change_r <= $past(change_r))

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench of the coin change dispenser, purchases checked against predicted change
module testbench;

  localparam int CLK_PERIOD   = 12;
  localparam int LIMIT_CYCLES = 400000;
  localparam int ITEMS_PER_PHASE = 75;

  // one expected result item
  typedef struct packed {
    ccd_pkg::status_t status;
    logic [3:0]       coin;
    logic [10:0]      count;
    logic [9:0]       empty;
    logic             is_last;
  } change_item_t;

  // coin stock model and queue of the change still to come
  class change_scoreboard;
    logic [15:0]  stock [10];
    change_item_t expected_change [$];
    int           errors;
    int           purchases;
    int           results;
    int           by_status [3];
    int           most_coins;

    function new();
      foreach (stock[i]) stock[i] = 16'd5;
      errors = 0;
      purchases = 0;
      results = 0;
      most_coins = 0;
      foreach (by_status[i]) by_status[i] = 0;
    endfunction

    function int unsigned cents(int idx);
      case (idx)
        0: return 1;
        1: return 2;
        2: return 5;
        3: return 10;
        4: return 20;
        5: return 50;
        6: return 100;
        7: return 200;
        8: return 500;
        default: return 1000;
      endcase
    endfunction

    function logic [9:0] empty_coins();
      logic [9:0] m;
      m = '0;
      foreach (stock[i]) if (stock[i] == 16'd0) m[i] = 1'b1;
      return m;
    endfunction

    function void push_single(ccd_pkg::status_t st);
      change_item_t r;
      r = '{status: st, coin: 4'd0, count: 11'd0, empty: empty_coins(), is_last: 1'b1};
      expected_change.push_back(r);
      by_status[st]++;
    endfunction

    // take in the payment, then pay the change greedily from the preferred coin down
    function void note_purchase(logic [10:0] paid_in, logic [10:0] price_in, logic [3:0] pref_in);
      int unsigned paid, price, rest, change, n, room;
      int          top, k;
      logic [15:0] saved [10];
      int unsigned used [10];
      logic [9:0]  mask;
      change_item_t r;
      purchases++;
      paid  = (paid_in > 11'd2000) ? 2000 : paid_in;
      price = (price_in > 11'd2000) ? 2000 : price_in;
      top   = (pref_in > 4'd9) ? 9 : pref_in;
      if (paid < price) begin
        push_single(ccd_pkg::ST_LOW);
        return;
      end
      saved = stock;
      rest = paid;
      for (int i = 9; i >= 0; i--) begin
        n = rest / cents(i);
        room = 65535 - stock[i];
        rest -= n * cents(i);
        stock[i] += 16'((n > room) ? room : n);
      end
      change = paid - price;
      for (int i = 0; i < 10; i++) used[i] = 0;
      for (int i = top; i >= 0; i--) begin
        n = change / cents(i);
        if (n > stock[i]) n = stock[i];
        stock[i] -= 16'(n);
        change -= n * cents(i);
        used[i] = n;
      end
      if (change != 0) begin
        stock = saved;
        push_single(ccd_pkg::ST_SHORT);
        return;
      end
      mask = empty_coins();
      k = 0;
      for (int i = top; i >= 0; i--) begin
        if (used[i] != 0) begin
          r = '{status: ccd_pkg::ST_PAID, coin: 4'(i), count: 11'(used[i]), empty: mask,
                is_last: 1'b0};
          expected_change.push_back(r);
          k++;
        end
      end
      if (k == 0) begin
        push_single(ccd_pkg::ST_PAID);
      end else begin
        expected_change[expected_change.size() - 1].is_last = 1'b1;
        by_status[ccd_pkg::ST_PAID]++;
        if (k > most_coins) most_coins = k;
      end
    endfunction

    function int pending();
      return expected_change.size();
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("mismatch at %0t: %s", $time, what);
    endtask

    task check_result(logic [1:0] st, logic [3:0] coin, logic [10:0] count,
                      logic [9:0] empty, logic is_last);
      change_item_t want;
      results++;
      if (expected_change.size() == 0) begin
        report_mismatch($sformatf("unexpected result status %0d coin %0d count %0d",
                                  st, coin, count));
        return;
      end
      want = expected_change.pop_front();
      if (st != want.status)
        report_mismatch($sformatf("status %0d, want %0d", st, want.status));
      if (coin != want.coin)
        report_mismatch($sformatf("coin index %0d, want %0d", coin, want.coin));
      if (count != want.count)
        report_mismatch($sformatf("coin count %0d, want %0d", count, want.count));
      if (empty != want.empty)
        report_mismatch($sformatf("empty mask %b, want %b", empty, want.empty));
      if (is_last != want.is_last)
        report_mismatch($sformatf("last %0d, want %0d", is_last, want.is_last));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  change_scoreboard ledger = new();

  // idle and stall chances in percent, and a requested long output hold
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_request = 0;

  coin_change_dispenser DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // run limit
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("timeout with %0d results outstanding", ledger.pending());
    $display("testbench: errors");
    $finish;
  end

  // result side: ready decided at the rising edge, handshake seen at the falling edge,
  // where everything is settled until the next rising edge takes the item
  initial begin
    int hold_left;
    hold_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
      @(negedge clk);
      if (rst_n && out_tvalid && out_tready)
        ledger.check_result(out_tuser, out_tdata[3:0], out_tdata[14:4], out_tdata[24:15],
                            out_tlast);
    end
  end

  // offers one purchase item, with random idle cycles ahead of it
  task automatic send_purchase(input logic [10:0] paid, input logic [10:0] price,
                               input logic [3:0] pref);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, pref, price, paid};
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    ledger.note_purchase(paid, price, pref);
    @(posedge clk);
  endtask

  task automatic stop_sending();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_all_change();
    while (ledger.pending() != 0) @(posedge clk);
  endtask

  // mostly plausible purchases, some below price, some small exact ones that refill
  // the small coins, and some raw noise over the full field ranges
  task automatic random_purchase();
    int kind, price, change, paid, pref;
    kind = $urandom_range(99);
    pref = ($urandom_range(99) < 85) ? $urandom_range(9) : $urandom_range(15, 10);
    if (kind < 10) begin
      paid  = $urandom_range(2047);
      price = $urandom_range(2047);
      pref  = $urandom_range(15);
    end else if (kind < 22) begin
      price = $urandom_range(2000, 1);
      paid  = $urandom_range(price - 1);
    end else if (kind < 35) begin
      price = $urandom_range(120, 1);
      paid  = price;
    end else begin
      price  = $urandom_range(1500);
      change = $urandom_range(1) ? $urandom_range(100) : $urandom_range(500);
      paid   = price + change;
    end
    if (paid > 2047) paid = 2047;
    send_purchase(11'(paid), 11'(price), 4'(pref));
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed purchases, no idling
    send_purchase(11'd0,    11'd0,    4'd0);   // exact payment of nothing
    send_purchase(11'd2047, 11'd2047, 4'd15);  // both amounts and coin index saturate
    send_purchase(11'd2000, 11'd2000, 4'd9);   // exact payment at the top
    send_purchase(11'd0,    11'd1,    4'd5);   // below price
    send_purchase(11'd1999, 11'd2000, 4'd9);   // one cent short of price
    send_purchase(11'd2047, 11'd2000, 4'd9);   // paid saturates to the price
    send_purchase(11'd2000, 11'd112,  4'd9);   // every denomination in the change
    send_purchase(11'd2000, 11'd112,  4'd15);  // same with preferred coin saturated
    send_purchase(11'd6,    11'd0,    4'd0);   // ones only
    send_purchase(11'd100,  11'd1,    4'd0);   // not enough ones, stock restored
    send_purchase(11'd500,  11'd0,    4'd8);   // single large coin
    send_purchase(11'd1000, 11'd0,    4'd0);   // large payment, change in ones only
    send_purchase(11'd150,  11'd35,   4'd4);
    send_purchase(11'd2047, 11'd0,    4'd9);   // largest change
    send_purchase(11'd1,    11'd1,    4'd0);
    send_purchase(11'd2046, 11'd1,    4'd3);   // change too big for dimes and below
    send_purchase(11'd5,    11'd0,    4'd2);
    send_purchase(11'd1365, 11'd682,  4'd10);
    stop_sending();
    wait_all_change();

    // random phases: none, sender idle, receiver stalling, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 65 : (ph == 3) ? 21 : 0;
      stall_pct     = (ph == 2) ? 65 : (ph == 3) ? 21 : 0;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) random_purchase();
      stop_sending();
      // sender pauses until all change is out
      wait_all_change();
    end

    // long output hold while purchases keep coming, so the input backs up
    send_idle_pct = 0;
    stall_pct = 0;
    hold_request = 400;
    for (int i = 0; i < 20; i++) random_purchase();
    stop_sending();
    wait_all_change();

    repeat (80) @(posedge clk);
    $display("covered %0d purchases and %0d change items, up to %0d coin kinds in one change",
             ledger.purchases, ledger.results, ledger.most_coins);
    $display("outcomes: %0d paid, %0d short of coins, %0d below price",
             ledger.by_status[ccd_pkg::ST_PAID], ledger.by_status[ccd_pkg::ST_SHORT],
             ledger.by_status[ccd_pkg::ST_LOW]);
    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
